// ===== rtl/core/lkvc_pkg.sv =====
package lkvc_pkg;

    // Fixed field widths of one transaction.
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Default build size and the capacity after reset.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Operation codes carried in the mode field.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Value returned by a lookup that misses.
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/core/lkvc_if.sv =====
interface lkvc_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [lkvc_pkg::KEY_W-1:0]    key;
    logic signed [lkvc_pkg::DATA_W-1:0]   value;

    modport source (output valid, output mode, output key, output value, input ready);
    modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic signed [lkvc_pkg::DATA_W-1:0]   read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

// ===== rtl/core/lru_key_value_cache.sv =====
// A get result is registered in the result register after the scan and decide states, and on a
// hit also after the rank update sweep; it is held back only while an earlier result is still waiting.
// The next transaction is accepted only once the control returns to idle: after the update sweep
// for a put, and after the result is registered for a get. The key match and rank update sweeps run
// over the entry memories through one shared compare unit.
// Reset (rst_n, asynchronous, active low) clears valid marks, count and control; capacity is 16.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lkvc_req_if.sink                      req,
    lkvc_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata
);

    // Index, rank and count widths all follow from the number of built entries.
    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    localparam logic [IW:0]     SWEEP_END = (IW+1)'(MAX_ENTRIES);
    localparam logic [IW-1:0]   LAST_IDX  = IW'(MAX_ENTRIES - 1);
    localparam logic [CMPW-1:0] MAX_CMP   = CMPW'(MAX_ENTRIES);

    // Control state.
    lkvc_pkg::state_t state_reg, state_next;

    logic [lkvc_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic [MAX_ENTRIES-1:0]     valid_reg, valid_next;
    logic [CW-1:0]              count_reg, count_next;

    // The sweep counter issues one memory read per cycle; stage one holds the read result.
    logic [IW:0]                cnt_reg, cnt_next;
    logic                       s1_vld_reg, s1_vld_next;
    logic [IW-1:0]              s1_idx_reg, s1_idx_next;

    // Results of the match sweep.
    logic                       hit_reg, hit_next;
    logic [IW-1:0]              hit_idx_reg, hit_idx_next;
    logic [RW-1:0]              hit_rank_reg, hit_rank_next;
    logic                       free_reg, free_next;
    logic [IW-1:0]              free_idx_reg, free_idx_next;
    logic                       vic_reg, vic_next;
    logic [IW-1:0]              vic_idx_reg, vic_idx_next;
    logic [RW-1:0]              vic_rank_reg, vic_rank_next;
    logic                       evict_reg, evict_next;
    logic [IW-1:0]              slot_reg, slot_next;

    // Captured transaction payload and looked-up data.
    logic                                 mode_reg, mode_next;
    logic signed [lkvc_pkg::KEY_W-1:0]    key_reg, key_next;
    logic signed [lkvc_pkg::DATA_W-1:0]   value_reg, value_next;
    logic signed [lkvc_pkg::DATA_W-1:0]   hit_data_reg, hit_data_next;

    // Result register; it lets a new transaction start while a result waits.
    logic                                 out_valid_reg, out_valid_next;
    logic                                 found_reg, found_next;
    logic signed [lkvc_pkg::DATA_W-1:0]   read_value_reg, read_value_next;

    // Entry memories, one write and one registered read per cycle each.
    logic signed [lkvc_pkg::KEY_W-1:0]    key_mem  [MAX_ENTRIES];
    logic signed [lkvc_pkg::DATA_W-1:0]   data_mem [MAX_ENTRIES];
    logic [RW-1:0]                        rank_mem [MAX_ENTRIES];
    logic signed [lkvc_pkg::KEY_W-1:0]    key_rd_reg;
    logic signed [lkvc_pkg::DATA_W-1:0]   data_rd_reg;
    logic [RW-1:0]                        rank_rd_reg;

    logic [IW-1:0]                        rd_addr;
    logic                                 kd_we;
    logic [IW-1:0]                        kd_wa;
    logic                                 rank_we;
    logic [RW-1:0]                        rank_wd;

    logic                                 accept;
    logic                                 issue;
    logic                                 last;
    logic                                 out_load;
    logic                                 e_valid;
    logic                                 key_match;
    logic [RW-1:0]                        cmp_b;
    logic                                 rank_ge;
    logic [RW-1:0]                        rank_inc;
    logic [CMPW-1:0]                      cap_cmp;
    logic [CMPW-1:0]                      eff_cap;
    logic                                 need_evict;
    logic [IW-1:0]                        slot_pick;

    assign req.ready      = (state_reg == lkvc_pkg::ST_IDLE);
    assign accept         = req.valid & req.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = read_value_reg;

    assign issue    = ((state_reg == lkvc_pkg::ST_SCAN) || (state_reg == lkvc_pkg::ST_UPDATE))
                      && (cnt_reg != SWEEP_END);
    assign rd_addr  = cnt_reg[IW-1:0];
    assign last     = s1_vld_reg && (s1_idx_reg == LAST_IDX);
    assign out_load = (state_reg == lkvc_pkg::ST_RESP) && (!out_valid_reg || rsp.ready);

    // The shared unit: one key comparator, one rank comparator and one rank incrementer,
    // applied to whichever entry sits in stage one this cycle.
    assign e_valid   = valid_reg[s1_idx_reg];
    assign key_match = e_valid && (key_rd_reg == key_reg);
    assign cmp_b     = (state_reg == lkvc_pkg::ST_SCAN) ? vic_rank_reg : hit_rank_reg;
    assign rank_ge   = (rank_rd_reg >= cmp_b);
    assign rank_inc  = rank_rd_reg + RW'(1);

    // Capacity zero acts as one, and values above the built size saturate.
    assign cap_cmp    = CMPW'(capacity_reg);
    assign eff_cap    = (cap_cmp == '0) ? CMPW'(1) : ((cap_cmp > MAX_CMP) ? MAX_CMP : cap_cmp);
    assign need_evict = (CMPW'(count_reg) >= eff_cap);

    // After an eviction the lowest free entry is either an older hole or the victim itself.
    assign slot_pick = (need_evict && !(free_reg && (free_idx_reg < vic_idx_reg)))
                       ? vic_idx_reg : free_idx_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN:
            begin
                if (last)
                begin
                    state_next = lkvc_pkg::ST_DECIDE;
                end
            end
            lkvc_pkg::ST_DECIDE:
            begin
                if ((mode_reg == lkvc_pkg::MODE_GET) && !hit_reg)
                begin
                    state_next = lkvc_pkg::ST_RESP;
                end
                else
                begin
                    state_next = lkvc_pkg::ST_UPDATE;
                end
            end
            lkvc_pkg::ST_UPDATE:
            begin
                if (last)
                begin
                    state_next = (mode_reg == lkvc_pkg::MODE_GET) ? lkvc_pkg::ST_RESP
                                                                  : lkvc_pkg::ST_IDLE;
                end
            end
            lkvc_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        capacity_next   = cfg_we ? cfg_wdata : capacity_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        cnt_next        = cnt_reg;
        s1_vld_next     = issue;
        s1_idx_next     = rd_addr;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_data_next   = hit_data_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        vic_next        = vic_reg;
        vic_idx_next    = vic_idx_reg;
        vic_rank_next   = vic_rank_reg;
        evict_next      = evict_reg;
        slot_next       = slot_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        found_next      = found_reg;
        read_value_next = read_value_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        kd_we           = 1'b0;
        kd_wa           = slot_pick;
        rank_we         = 1'b0;
        rank_wd         = rank_inc;

        if (issue)
        begin
            cnt_next = cnt_reg + (IW+1)'(1);
        end
        else if (last)
        begin
            cnt_next = '0;
        end

        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = req.mode;
                    key_next   = req.key;
                    value_next = req.value;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    vic_next   = 1'b0;
                end
            end
            lkvc_pkg::ST_SCAN:
            begin
                if (s1_vld_reg)
                begin
                    if (key_match && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = s1_idx_reg;
                        hit_rank_next = rank_rd_reg;
                        hit_data_next = data_rd_reg;
                    end
                    if (!e_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = s1_idx_reg;
                    end
                    // Ties go to the later entry, so the highest rank found last wins.
                    if (e_valid && (!vic_reg || rank_ge))
                    begin
                        vic_next      = 1'b1;
                        vic_idx_next  = s1_idx_reg;
                        vic_rank_next = rank_rd_reg;
                    end
                end
            end
            lkvc_pkg::ST_DECIDE:
            begin
                evict_next = need_evict && vic_reg;
                slot_next  = slot_pick;
                if (mode_reg == lkvc_pkg::MODE_PUT)
                begin
                    kd_we = 1'b1;
                    kd_wa = hit_reg ? hit_idx_reg : slot_pick;
                end
            end
            lkvc_pkg::ST_UPDATE:
            begin
                if (s1_vld_reg)
                begin
                    if (hit_reg)
                    begin
                        // Touch: the hit entry becomes newest, newer ones age by one.
                        if (s1_idx_reg == hit_idx_reg)
                        begin
                            rank_we = 1'b1;
                            rank_wd = '0;
                        end
                        else if (e_valid && !rank_ge)
                        begin
                            rank_we = 1'b1;
                        end
                    end
                    else
                    begin
                        // Insert: every surviving entry ages, the new one is newest.
                        if (s1_idx_reg == slot_reg)
                        begin
                            rank_we = 1'b1;
                            rank_wd = '0;
                        end
                        else if (e_valid && !(evict_reg && (s1_idx_reg == vic_idx_reg)))
                        begin
                            rank_we = 1'b1;
                        end
                    end
                end
                if (last && !hit_reg)
                begin
                    if (evict_reg)
                    begin
                        valid_next[vic_idx_reg] = 1'b0;
                    end
                    valid_next[slot_reg] = 1'b1;
                    if (!evict_reg)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            lkvc_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = hit_reg;
                    read_value_next = hit_reg ? hit_data_reg : lkvc_pkg::MISS_VALUE;
                end
            end
            default:
            begin
                rank_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkvc_pkg::ST_IDLE;
            capacity_reg  <= lkvc_pkg::CAPACITY_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            s1_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            vic_reg       <= 1'b0;
            evict_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            s1_vld_reg    <= s1_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            vic_reg       <= vic_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg     <= s1_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        hit_data_reg   <= hit_data_next;
        free_idx_reg   <= free_idx_next;
        vic_idx_reg    <= vic_idx_next;
        vic_rank_reg   <= vic_rank_next;
        slot_reg       <= slot_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        found_reg      <= found_next;
        read_value_reg <= read_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (kd_we)
        begin
            key_mem[kd_wa] <= key_reg;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (kd_we)
        begin
            data_mem[kd_wa] <= value_reg;
        end
        data_rd_reg <= data_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[s1_idx_reg] <= rank_wd;
        end
        rank_rd_reg <= rank_mem[rd_addr];
    end

    // The entry count always equals the number of valid marks.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count disagrees with valid marks");

    // An insert lands on a free entry or on the entry being evicted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkvc_pkg::ST_UPDATE && !hit_reg)
        |-> (!valid_reg[slot_reg] || (evict_reg && (slot_reg == vic_idx_reg))))
        else $error("insert would overwrite a live entry");

    // A new result appears only out of the response state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == lkvc_pkg::ST_RESP))
        else $error("result raised outside the response state");

    // A put never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load) |-> (mode_reg == lkvc_pkg::MODE_GET))
        else $error("result produced for a put");

endmodule
